@@ design/ndtp_pkg.sv @@
// shared types, constants and helper functions for the duration text parser
package ndtp_pkg;

  localparam int MAX_DOTS  = 15;
  localparam int NUM_LIMIT = 65535;

  localparam int CH_W      = 8;
  localparam int QT_W      = 16;
  localparam int DD_W      = 20;
  localparam int BASE_W    = 20;
  localparam int NUM_W     = 16;
  localparam int DOTS_W    = 4;
  localparam int DVAL_W    = 21;
  localparam int DUR_W     = 37;
  localparam int ALU_W     = 38;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_STEPS = NUM_W;
  localparam int DIV_STEPS = DUR_W;
  localparam int CNT_W     = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUARTER = 2'd0,
    CFG_DEFAULT = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PS_FIRST,
    PS_DOTS,
    PS_MULT,
    PS_SEEK,
    PS_DIV,
    PS_DONE
  } stage_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_DOTS,
    SQ_MUL,
    SQ_DIV,
    SQ_LOAD
  } seq_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } letter_t;

  function automatic letter_t letter_lookup(input logic [CH_W-1:0] c);
    letter_t          r;
    logic [CH_W-1:0]  lc;
    lc = c;
    if (c inside {["A":"Z"]}) begin
      lc = c | 8'h20;
    end
    r.hit = 1'b1;
    r.idx = 4'd0;
    case (lc)
      "d": r.idx = 4'd0;
      "w": r.idx = 4'd1;
      "h": r.idx = 4'd2;
      "q": r.idx = 4'd3;
      "e": r.idx = 4'd4;
      "s": r.idx = 4'd5;
      "t": r.idx = 4'd6;
      "f": r.idx = 4'd7;
      "o": r.idx = 4'd8;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return c inside {["0":"9"]};
  endfunction

  // acc * 10 + digit, clamped at the number limit
  function automatic logic [NUM_W-1:0] accumulate(input logic [NUM_W-1:0] acc,
                                                  input logic [CH_W-1:0]  c);
    logic [NUM_W+4:0] v;
    v = (NUM_W+5)'({acc, 3'b000}) + (NUM_W+5)'({acc, 1'b0}) + (NUM_W+5)'(c - "0");
    if (v > (NUM_W+5)'(NUM_LIMIT)) begin
      return NUM_W'(NUM_LIMIT);
    end
    return v[NUM_W-1:0];
  endfunction

endpackage

@@ design/ndtp_if.sv @@
// valid/ready channel interfaces for character beats and duration results
interface ndtp_char_if import ndtp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ndtp_dur_if import ndtp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] duration;

  modport source (output valid, output duration, input ready);
  modport sink   (input valid, input duration, output ready);
endinterface

@@ design/note_duration_text_parser.sv @@
// top level of the note duration text parser
// Takes a duration name one character beat at a time (ready every cycle while
// parsing) and, after the beat flagged last, computes one tick count. The
// finish runs on a single shared 38-bit add/subtract unit: the dot scaling,
// then msb-first shift-add when a multiplier is present and restoring
// division when a divisor is present, then a load of the output register.
// The input is not ready during the finish, and the load waits for as long
// as an earlier result is still unclaimed. The finished result sits in an
// output register, so the next name can be parsed while it waits to be taken.
module note_duration_text_parser import ndtp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  ndtp_char_if.sink            chars,
  ndtp_dur_if.source           result
);

  // configuration registers
  logic [QT_W-1:0] quarter_ticks;
  logic [DD_W-1:0] default_duration;

  // parse state
  stage_t            stage, stage_next;
  logic [BASE_W-1:0] base_ticks, base_ticks_next;
  logic [DOTS_W-1:0] dot_count, dot_count_next;
  logic [NUM_W-1:0]  multiplier, multiplier_next;
  logic [NUM_W-1:0]  divisor, divisor_next;

  // finish sequencer and datapath
  seq_t              seq, seq_next;
  logic [CNT_W-1:0]  cnt;
  logic [DUR_W-1:0]  acc;
  logic [DVAL_W-1:0] mcand;
  logic [NUM_W-1:0]  rem;
  logic [DUR_W-1:0]  out_dur;
  logic              out_valid;

  // shared unit
  logic [ALU_W-1:0]  alu_a, alu_b, alu_sum;
  logic              alu_sub;
  logic              borrow;
  logic [DVAL_W-1:0] dots_val;

  logic    in_beat, out_free, cnt_end_mul, cnt_end_div;
  letter_t lk;
  stage_t  eff_stage;

  assign in_beat     = chars.valid && chars.ready;
  assign out_free    = !out_valid || result.ready;
  assign cnt_end_mul = (cnt == CNT_W'(MUL_STEPS - 1));
  assign cnt_end_div = (cnt == CNT_W'(DIV_STEPS - 1));

  // character parse, one beat per cycle while no finish is running
  always_comb begin
    stage_next      = stage;
    base_ticks_next = base_ticks;
    dot_count_next  = dot_count;
    multiplier_next = multiplier;
    divisor_next    = divisor;
    eff_stage       = stage;
    lk              = letter_lookup(chars.ch);
    if (stage == PS_FIRST) begin
      stage_next = PS_DOTS;
      if (lk.hit) begin
        // a leading letter only sets the base
        base_ticks_next = BASE_W'({quarter_ticks, 3'b000} >> lk.idx);
        eff_stage       = PS_DONE;
      end else begin
        // no letter: default base, then the char is parsed as a dot run char
        base_ticks_next = BASE_W'(default_duration);
        eff_stage       = PS_DOTS;
      end
    end
    if (!(stage == PS_FIRST && lk.hit)) begin
      case (eff_stage)
        PS_DOTS, PS_MULT: begin
          if (eff_stage == PS_DOTS && chars.ch == ".") begin
            if (dot_count < DOTS_W'(MAX_DOTS)) begin
              dot_count_next = dot_count + DOTS_W'(1);
            end
          end else if (is_digit(chars.ch)) begin
            multiplier_next = accumulate(multiplier, chars.ch);
            stage_next      = PS_MULT;
          end else if (chars.ch == "/") begin
            stage_next = PS_DIV;
          end else if (chars.ch == 8'h00) begin
            stage_next = PS_DONE;
          end else begin
            stage_next = PS_SEEK;
          end
        end
        PS_SEEK: begin
          if (chars.ch == "/") begin
            stage_next = PS_DIV;
          end else if (chars.ch == 8'h00) begin
            stage_next = PS_DONE;
          end
        end
        PS_DIV: begin
          if (is_digit(chars.ch)) begin
            divisor_next = accumulate(divisor, chars.ch);
          end else begin
            stage_next = PS_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    seq_next = seq;
    case (seq)
      SQ_IDLE: begin
        if (in_beat && chars.last) begin
          seq_next = SQ_DOTS;
        end
      end
      SQ_DOTS: begin
        if (multiplier != '0) begin
          seq_next = SQ_MUL;
        end else if (divisor != '0) begin
          seq_next = SQ_DIV;
        end else begin
          seq_next = SQ_LOAD;
        end
      end
      SQ_MUL: begin
        if (cnt_end_mul) begin
          seq_next = (divisor != '0) ? SQ_DIV : SQ_LOAD;
        end
      end
      SQ_DIV: begin
        if (cnt_end_div) begin
          seq_next = SQ_LOAD;
        end
      end
      SQ_LOAD: begin
        if (out_free) begin
          seq_next = SQ_IDLE;
        end
      end
      default: seq_next = SQ_IDLE;
    endcase
  end

  // sequencer outputs: operand steering for the shared add/subtract unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (seq)
      SQ_DOTS: begin
        // (base << (k+1)) - base, shifted right by k below
        alu_a   = ALU_W'(base_ticks) << ({1'b0, dot_count} + 5'd1);
        alu_b   = ALU_W'(base_ticks);
        alu_sub = 1'b1;
      end
      SQ_MUL: begin
        // msb-first shift-add; the product starts from zero
        alu_a = (cnt == '0) ? '0 : ALU_W'({acc, 1'b0});
        alu_b = multiplier[NUM_W-1] ? ALU_W'(mcand) : '0;
      end
      SQ_DIV: begin
        // restoring divide: trial subtract of the divisor
        alu_a   = ALU_W'({rem, acc[DUR_W-1]});
        alu_b   = ALU_W'(divisor);
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign chars.ready = (seq == SQ_IDLE);
  assign alu_sum     = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
  assign borrow      = alu_sum[ALU_W-1];
  assign dots_val    = DVAL_W'(alu_sum >> dot_count);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_ticks    <= QT_W'(384);
      default_duration <= DD_W'(1536);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUARTER: quarter_ticks    <= cfg_data[QT_W-1:0];
        CFG_DEFAULT: default_duration <= cfg_data[DD_W-1:0];
        default: ;
      endcase
    end
  end

  // control state and parse registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq        <= SQ_IDLE;
      stage      <= PS_FIRST;
      base_ticks <= '0;
      dot_count  <= '0;
      multiplier <= '0;
      divisor    <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      seq <= seq_next;
      // a new result replaces the old one in the cycle it is taken
      if (seq == SQ_LOAD && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (seq)
        SQ_IDLE: begin
          if (in_beat) begin
            stage      <= stage_next;
            base_ticks <= base_ticks_next;
            dot_count  <= dot_count_next;
            multiplier <= multiplier_next;
            divisor    <= divisor_next;
          end
        end
        SQ_DOTS: cnt <= '0;
        SQ_MUL: begin
          multiplier <= multiplier << 1;
          cnt        <= cnt_end_mul ? '0 : cnt + CNT_W'(1);
        end
        SQ_DIV: cnt <= cnt + CNT_W'(1);
        SQ_LOAD: begin
          if (out_free) begin
            stage      <= PS_FIRST;
            base_ticks <= '0;
            dot_count  <= '0;
            multiplier <= '0;
            divisor    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (seq != SQ_DIV) begin
      rem <= '0;
    end
    case (seq)
      SQ_DOTS: begin
        acc   <= DUR_W'(dots_val);
        mcand <= dots_val;
      end
      SQ_MUL: acc <= alu_sum[DUR_W-1:0];
      SQ_DIV: begin
        rem <= borrow ? {rem[NUM_W-2:0], acc[DUR_W-1]} : alu_sum[NUM_W-1:0];
        acc <= {acc[DUR_W-2:0], !borrow};
      end
      SQ_LOAD: begin
        if (out_free) begin
          out_dur <= acc;
        end
      end
      default: ;
    endcase
  end

  assign result.valid    = out_valid;
  assign result.duration = out_dur;

  // a last beat always starts the finish
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    in_beat && chars.last |=> seq == SQ_DOTS)
    else $error("last beat did not start the finish");

  // the running remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    seq == SQ_DIV |-> rem < divisor)
    else $error("divide remainder out of range");

  // loading a result leaves the parser cleared and the result shown
  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    seq == SQ_LOAD && out_free |=> out_valid && stage == PS_FIRST && dot_count == '0)
    else $error("result load did not clear the parse state");

endmodule

@@ tb/note_duration_text_parser_test.sv @@
// self-checking testbench for the note duration text parser
module note_duration_text_parser_test;
  import ndtp_pkg::*;

  // register indexes past the last real register, written to show they do nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // characters the parser gives a meaning to
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_UP_A  = "A";
  localparam logic [7:0] CH_UP_Z  = "Z";
  localparam logic [71:0] DUR_LETTERS = "dwhqestfo";

  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned SETTLE_CYCLES = 64;   // longer than the slowest finish
  localparam int unsigned LONG_HOLD     = 600;
  localparam int unsigned PHASE_CHARS   = 300;
  localparam int unsigned MAX_PRINTED   = 30;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } char_beat_t;

  typedef logic [CH_W-1:0] name_q_t[$];

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ndtp_char_if chars_if ();
  ndtp_dur_if  dur_if ();

  note_duration_text_parser dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chars     (chars_if),
    .result    (dur_if)
  );

  // stimulus waiting to be offered, and durations the block still owes us
  char_beat_t       chars_pending[$];
  logic [DUR_W-1:0] durations_due[$];

  // shadow of the configuration registers
  logic [QT_W-1:0] quarter_shadow;
  logic [DD_W-1:0] default_shadow;

  // shadow of the parse in progress
  stage_t           name_stage;
  logic [DVAL_W-1:0] name_base;
  logic [DOTS_W-1:0] name_dots;
  logic [NUM_W-1:0]  name_mult;
  logic [NUM_W-1:0]  name_div;

  int unsigned errors;
  int unsigned chars_queued;
  int unsigned chars_taken;
  int unsigned names_taken;
  int unsigned durations_checked;
  int unsigned settings_run;
  int unsigned cycle_count;

  // sender burst shaping
  int unsigned burst_left;
  int unsigned gap_left;

  // receiver stall shaping
  logic        hold_go;
  int unsigned hold_left;
  int unsigned ready_mode;
  int unsigned mode_left;

  // ---------------------------------------------------------------------------
  // prediction of the parse
  // ---------------------------------------------------------------------------

  function automatic void clear_name_state();
    name_stage = PS_FIRST;
    name_base  = '0;
    name_dots  = '0;
    name_mult  = '0;
    name_div   = '0;
  endfunction

  function automatic logic char_is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // decimal accumulation, pinned at the number limit
  function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] acc,
                                                 input logic [7:0]       c);
    logic [31:0] v;
    v = 32'(acc) * 32'd10 + 32'(c - CH_ZERO);
    return (v > 32'(NUM_LIMIT)) ? NUM_W'(NUM_LIMIT) : v[NUM_W-1:0];
  endfunction

  // where the parse goes once a dot run or multiplier ends on a non-digit
  function automatic stage_t stage_after_number(input logic [7:0] c);
    if (c == CH_SLASH) return PS_DIV;
    if (c == CH_NUL) return PS_DONE;
    return PS_SEEK;
  endfunction

  function automatic void take_name_char(input logic [7:0] c);
    logic [7:0] lc;
    logic       found;
    int         idx;
    found = 1'b0;
    idx   = 0;
    if (name_stage == PS_FIRST) begin
      lc = c;
      if ((c >= CH_UP_A) && (c <= CH_UP_Z)) lc = c + 8'd32;
      for (int k = 0; k < 9; k++) begin
        if (!found && (lc == DUR_LETTERS[71-8*k -: 8])) begin
          found = 1'b1;
          idx   = k;
        end
      end
    end
    if (found) begin
      // a duration letter only sets the base: eight quarters halved per index
      name_base  = DVAL_W'({quarter_shadow, 3'b000}) >> idx;
      name_stage = PS_DOTS;
    end else begin
      // no letter: the same character is parsed again as dot, digit or other
      if (name_stage == PS_FIRST) begin
        name_base  = DVAL_W'(default_shadow);
        name_stage = PS_DOTS;
      end
      case (name_stage)
        PS_DOTS: begin
          if (c == CH_DOT) begin
            if (name_dots < DOTS_W'(MAX_DOTS)) name_dots = name_dots + 1'b1;
          end else if (char_is_digit(c)) begin
            name_mult  = add_digit(name_mult, c);
            name_stage = PS_MULT;
          end else begin
            name_stage = stage_after_number(c);
          end
        end
        PS_MULT: begin
          if (char_is_digit(c)) name_mult = add_digit(name_mult, c);
          else name_stage = stage_after_number(c);
        end
        PS_SEEK: begin
          if (c == CH_SLASH) name_stage = PS_DIV;
          else if (c == CH_NUL) name_stage = PS_DONE;
        end
        PS_DIV: begin
          if (char_is_digit(c)) name_div = add_digit(name_div, c);
          else name_stage = PS_DONE;
        end
        default: begin
        end
      endcase
    end
  endfunction

  // dots scale first (multiply then shift), then multiplier, then divisor
  function automatic logic [DUR_W-1:0] name_duration();
    logic [63:0] d;
    d = 64'(name_base);
    if (name_dots != 0) d = (d * ((64'd2 << name_dots) - 64'd1)) >> name_dots;
    if (name_mult != 0) d = d * 64'(name_mult);
    if (name_div != 0) d = d / 64'(name_div);
    return d[DUR_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_name(input name_q_t nm);
    foreach (nm[i]) begin
      chars_pending.push_back('{ch: nm[i], last: (i == nm.size() - 1)});
      chars_queued++;
    end
  endtask

  task automatic push_text(input string s);
    name_q_t nm;
    nm = {};
    for (int i = 0; i < s.len(); i++) nm.push_back(s[i]);
    push_name(nm);
  endtask

  task automatic add_digits(ref name_q_t nm);
    int unsigned n;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
    repeat (n) nm.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // mostly well-formed names with random content, some broken, some pure noise
  task automatic gen_name();
    name_q_t     nm;
    int unsigned r;
    int unsigned n;
    logic [7:0]  c;
    nm = {};
    r  = $urandom_range(0, 99);
    if (r < 15) begin
      n = $urandom_range(1, 8);
      repeat (n) nm.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) != 0) begin
        c = DUR_LETTERS[71-8*$urandom_range(0, 8) -: 8];
        if ($urandom_range(0, 1) == 1) c = c - 8'd32;
        nm.push_back(c);
      end
      r = $urandom_range(0, 99);
      if (r < 35) n = $urandom_range(1, 3);
      else if (r < 50) n = $urandom_range(4, 20);
      else n = 0;
      repeat (n) nm.push_back(CH_DOT);
      if ($urandom_range(0, 1) == 1) add_digits(nm);
      // stray text before the slash gets skipped
      if ($urandom_range(0, 9) == 0) nm.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 45) begin
        nm.push_back(CH_SLASH);
        if ($urandom_range(0, 5) != 0) add_digits(nm);
      end
      // anything after the divisor ends the parse
      if ($urandom_range(0, 9) == 0) nm.push_back(8'($urandom_range(0, 255)));
      // broken names: a sign, space, nul or random byte dropped in anywhere
      if ($urandom_range(0, 99) < 18) begin
        case ($urandom_range(0, 4))
          0: c = " ";
          1: c = "+";
          2: c = "-";
          3: c = CH_NUL;
          default: c = 8'($urandom_range(0, 255));
        endcase
        nm.insert($urandom_range(0, nm.size()), c);
      end
    end
    if (nm.size() == 0) nm.push_back(8'($urandom_range(0, 255)));
    push_name(nm);
  endtask

  task automatic gen_phase();
    int unsigned goal;
    goal = chars_queued + PHASE_CHARS;
    while (chars_queued < goal) gen_name();
  endtask

  // registers only change while nothing is in flight
  task automatic wait_idle();
    do @(negedge clk);
    while (chars_pending.size() != 0 || chars_if.valid || durations_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_QUARTER: quarter_shadow = data[QT_W-1:0];
      CFG_DEFAULT: default_shadow = data[DD_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_durations(input logic [QT_W-1:0] qt, input logic [DD_W-1:0] dd);
    // upper data bits of the quarter write are junk that must be dropped
    write_reg(CFG_QUARTER, {4'($urandom_range(0, 15)), qt});
    write_reg(CFG_DEFAULT, dd);
    settings_run++;
  endtask

  task automatic pulse_hold();
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [DUR_W-1:0] got,
                                 input logic [DUR_W-1:0] want);
    if (errors < MAX_PRINTED)
      $display("mismatch: %s: got %0d expected %0d (beat %0d)", what, got, want,
               durations_checked);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // clock, cycle count and timeout
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d durations still due", cycle_count,
             durations_due.size());
    $display("note_duration_text_parser_test NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // character driver: bursts of random length separated by random gaps;
  // the expected duration is worked out the moment the last beat is taken
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    logic       nxt_valid;
    char_beat_t beat;
    if (rst) begin
      chars_if.valid <= 1'b0;
      burst_left     <= 0;
      gap_left       <= 0;
    end else begin
      nxt_valid = chars_if.valid;
      if (chars_if.valid && chars_if.ready) begin
        take_name_char(chars_if.ch);
        chars_taken++;
        if (chars_if.last) begin
          durations_due.push_back(name_duration());
          clear_name_state();
          names_taken++;
        end
        nxt_valid = 1'b0;
      end
      // a beat not yet taken is held; otherwise load the next one unless in a gap
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (chars_pending.size() != 0) begin
          beat = chars_pending.pop_front();
          chars_if.ch   <= beat.ch;
          chars_if.last <= beat.last;
          nxt_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 12);
            // zero gaps give stretches with no idling at all
            gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      chars_if.valid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: long hold-off on request, otherwise a rotating stall pattern
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_go) hold_left <= LONG_HOLD;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst) begin
      dur_if.ready <= 1'b0;
      ready_mode   <= 0;
      mode_left    <= 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_go || hold_left != 0) begin
        dur_if.ready <= 1'b0;
      end else begin
        case (ready_mode)
          0: dur_if.ready <= 1'b1;
          1: dur_if.ready <= 1'($urandom_range(0, 1));
          2: dur_if.ready <= ($urandom_range(0, 5) == 0);
          default: dur_if.ready <= (cycle_count[2:0] == 3'd3) || (cycle_count[2:0] == 3'd6);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: every duration beat is matched against the oldest one due
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    logic [DUR_W-1:0] want;
    if (!rst && dur_if.valid && dur_if.ready) begin
      if (durations_due.size() == 0) begin
        report_mismatch("duration with nothing due", dur_if.duration, '0);
      end else begin
        want = durations_due.pop_front();
        if (dur_if.duration !== want) report_mismatch("duration", dur_if.duration, want);
      end
      durations_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    name_q_t nm;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_QUARTER;
    cfg_data       = '0;
    chars_if.valid = 1'b0;
    chars_if.ch    = '0;
    chars_if.last  = 1'b0;
    dur_if.ready   = 1'b0;
    hold_go        = 1'b0;
    quarter_shadow = QT_W'(384);
    default_shadow = DD_W'(1536);
    clear_name_state();
    errors            = 0;
    chars_queued      = 0;
    chars_taken       = 0;
    names_taken       = 0;
    durations_checked = 0;
    settings_run      = 1;
    cycle_count       = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed names under the reset register values
    push_text("q");        // plain letter
    push_text("O");        // upper-case letter, last index
    push_text(".");        // leading dot, default base
    push_text("h...");     // dotted
    push_text("s3/2");     // multiplier and divisor
    push_text("99999");    // multiplier pinned at the limit
    nm = {CH_NUL, "x"};    // nul ends the parse, the rest is ignored
    push_name(nm);
    push_text("t-4");      // sign is not skipped, number never starts
    push_text("/0");       // zero divisor is not applied
    nm = {8'hFF};          // top character code, not a letter
    push_name(nm);
    gen_phase();
    wait_idle();

    // smallest quarter and zero default, plus writes to the spare indexes
    set_durations(QT_W'(1), DD_W'(0));
    write_reg(REG_SPARE_2, 20'hFFFFF);
    write_reg(REG_SPARE_3, CFG_W'($urandom_range(0, 1048575)));
    gen_phase();
    wait_idle();

    // largest values; the receiver holds off long enough to back the input up
    set_durations(QT_W'(65535), DD_W'(1048575));
    gen_phase();
    pulse_hold();
    wait_idle();

    repeat (2) begin
      set_durations(QT_W'($urandom_range(1, 65535)), DD_W'($urandom_range(0, 1048575)));
      gen_phase();
      wait_idle();
    end

    set_durations(QT_W'($urandom_range(1, 255)), DD_W'($urandom_range(0, 4095)));
    gen_phase();
    pulse_hold();
    wait_idle();

    $display("ran %0d characters in %0d names over %0d register settings",
             chars_taken, names_taken, settings_run);
    $display("checked %0d durations, %0d mismatches, %0d cycles",
             durations_checked, errors, cycle_count);
    if (errors == 0 && durations_due.size() == 0) begin
      $display("note_duration_text_parser_test OK");
    end else begin
      $display("note_duration_text_parser_test NOT OK");
    end
    $finish;
  end

endmodule
